// ===== sv/ymr_pkg.sv =====
// package: types, constants and crc step for the ymodem receiver
package ymr_pkg;
   localparam int unsigned PayloadBytesDefault = 128;
   localparam int unsigned PosMax = 2047;
   localparam logic [7:0] ChSoh = 8'h01;
   localparam logic [7:0] ChEot = 8'h04;
   localparam logic [7:0] ChAck = 8'h06;
   localparam logic [7:0] ChNak = 8'h15;
   localparam logic [7:0] ChC = 8'h43;

   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_ERASE = 2'd1,
      KIND_WRITE = 2'd2,
      KIND_RESET = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      PH_START = 2'd0,
      PH_DATA  = 2'd1,
      PH_EOT2  = 2'd2,
      PH_FINAL = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      CSR_BASE = 2'd0,
      CSR_SIZE = 2'd1,
      CSR_DONE = 2'd2,
      CSR_POLY = 2'd3
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SEQ   = 5'b00010,
      ST_READ  = 5'b00100,
      ST_WORD  = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   function automatic logic [15:0] crc_step(input logic [15:0] crc_in,
                                            input logic [7:0] data,
                                            input logic [15:0] poly);
      logic [15:0] c;
      c = crc_in ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) c = {c[14:0], 1'b0} ^ poly;
         else c = {c[14:0], 1'b0};
      end
      return c;
   endfunction
endpackage

// ===== sv/ymr_if.sv =====
// interfaces for the request and response channels
interface ymr_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] rx_byte;
   logic       frame_end;
   modport source (output valid, op, rx_byte, frame_end, input ready);
   modport sink (input valid, op, rx_byte, frame_end, output ready);
endinterface

interface ymr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  tx_byte;
   logic [31:0] address;
   logic [31:0] data_word;
   logic [31:0] region_end;
   logic        last;
   modport source (output valid, kind, tx_byte, address, data_word, region_end, last,
                   input ready);
   modport sink (input valid, kind, tx_byte, address, data_word, region_end, last,
                 output ready);
endinterface

// ===== sv/ymr_ram.sv =====
// generic single-port ram with registered read
module ymr_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule

// ===== sv/ymodem_receiver_with_crc16.sv =====
// top level of the ymodem receiver with crc-16 frame check
//  channel  | dir | handshake        | payload
//  req      | in  | valid/ready      | op, rx_byte, frame_end
//  rsp      | out | valid/ready      | kind, tx_byte, address, data_word, region_end, last
//  csr      | in  | write enable     | csr_index, csr_wdata
// a byte is taken on each valid/ready handshake, crc updated on the way into the payload ram.
// a good data frame drains PAYLOAD_BYTES/4 words (32 by default), each by address set-up, four byte
// reads over the single ram port and output, then an ack; control replies are one to three responses.
// synchronous reset clears control state; the ram needs no clearing.
// req stalls while results are pending; rsp holds while ready is low.
module ymodem_receiver_with_crc16
   import ymr_pkg::*;
#(
   parameter int unsigned PAYLOAD_BYTES = PayloadBytesDefault
) (
   input  logic        clock,
   input  logic        reset,
   ymr_req_if.sink     req,
   ymr_rsp_if.source   rsp,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   localparam int unsigned AW = $clog2(PAYLOAD_BYTES);
   localparam int unsigned NW = PAYLOAD_BYTES / 4;
   localparam int unsigned WW = $clog2(NW);
   localparam logic [10:0] FrameLen = 11'(PAYLOAD_BYTES + 5);
   localparam logic [10:0] CrcHiPos = 11'(PAYLOAD_BYTES + 3);
   localparam logic [10:0] CrcLoPos = 11'(PAYLOAD_BYTES + 4);
   localparam int unsigned PcShift = $clog2(PAYLOAD_BYTES);

   logic [31:0] base_ff, size_ff, done_ff;
   logic [15:0] poly_ff;
   phase_type   phase_ff, phase_in;
   logic [7:0]  exp_ff, exp_in;
   logic [15:0] pc_ff, pc_in;
   logic [10:0] pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  hdr_ff [5];
   state_type   st_ff, st_in;
   logic [1:0]  seq_ff, seq_in;     // which control sequence
   logic [1:0]  step_ff, step_in;
   logic [WW-1:0] word_ff, word_in;
   logic [1:0]  bsel_ff, bsel_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] wbase_ff, wbase_in;

   logic        o_valid_ff, o_valid_in, o_last_ff, o_last_in;
   kind_type    o_kind_ff, o_kind_in;
   logic [7:0]  o_tx_ff, o_tx_in;
   logic [31:0] o_addr_ff, o_addr_in, o_data_ff, o_data_in, o_rend_ff, o_rend_in;

   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [7:0]    ram_rdata;

   ymr_ram #(.Width(8), .Depth(PAYLOAD_BYTES)) u_ram (
      .clock(clock), .we(ram_we), .addr(ram_addr), .wdata(req.rx_byte), .rdata(ram_rdata)
   );

   localparam logic [1:0] SqStart = 2'd0, SqFinal = 2'd1, SqNak = 2'd2, SqEot = 2'd3;

   logic accept, in_payload, frame_ok, cpl;
   logic [7:0] h0, h1, h2, h3, h4;
   logic [10:0] pos_cur;

   assign req.ready = st_ff == ST_IDLE && !o_valid_ff;
   assign accept = req.valid && req.ready;
   assign pos_cur = pos_ff;
   assign in_payload = pos_cur >= 11'd3 && pos_cur < CrcHiPos;
   assign ram_we = accept && !req.op && in_payload;

   always_comb begin
      h0 = hdr_ff[0]; h1 = hdr_ff[1]; h2 = hdr_ff[2]; h3 = hdr_ff[3]; h4 = hdr_ff[4];
      if (pos_cur == 11'd0) h0 = req.rx_byte;
      if (pos_cur == 11'd1) h1 = req.rx_byte;
      if (pos_cur == 11'd2) h2 = req.rx_byte;
      if (pos_cur == CrcHiPos) h3 = req.rx_byte;
      if (pos_cur == CrcLoPos) h4 = req.rx_byte;
   end
   assign cpl = h2 == ~h1;
   assign frame_ok = (pos_cur + 11'd1 == FrameLen) && ({h3, h4} == crc_ff) && cpl;

   always_comb begin
      ram_addr = AW'(pos_cur - 11'd3);
      if (st_ff == ST_READ || st_ff == ST_WORD) ram_addr = {word_ff, bsel_ff};
   end

   always_comb begin
      phase_in = phase_ff; exp_in = exp_ff; pc_in = pc_ff; pos_in = pos_ff; crc_in = crc_ff;
      st_in = st_ff; seq_in = seq_ff; step_in = step_ff; word_in = word_ff;
      bsel_in = bsel_ff; acc_in = acc_ff; wbase_in = wbase_ff;
      o_valid_in = o_valid_ff; o_last_in = o_last_ff; o_kind_in = o_kind_ff;
      o_tx_in = o_tx_ff; o_addr_in = o_addr_ff; o_data_in = o_data_ff; o_rend_in = o_rend_ff;
      if (o_valid_ff && rsp.ready) o_valid_in = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req.op) begin
                  if (phase_ff == PH_START) begin
                     o_valid_in = 1'b1; o_last_in = 1'b1; o_kind_in = KIND_BYTE;
                     o_tx_in = ChC; o_addr_in = '0; o_data_in = '0; o_rend_in = '0;
                  end
               end else begin
                  if (in_payload) crc_in = crc_step(crc_ff, req.rx_byte, poly_ff);
                  if (req.frame_end) begin
                     pos_in = '0; crc_in = '0;
                     if (h0 == ChSoh && frame_ok) begin
                        if (phase_ff == PH_START && h1 == 8'h00) begin
                           phase_in = PH_DATA; exp_in = 8'd1; pc_in = '0;
                           st_in = ST_SEQ; seq_in = SqStart; step_in = '0;
                        end else if (phase_ff == PH_FINAL && h1 == 8'h00) begin
                           phase_in = PH_START;
                           st_in = ST_SEQ; seq_in = SqFinal; step_in = '0;
                        end else if (phase_ff == PH_DATA && h1 == exp_ff) begin
                           wbase_in = base_ff + ({16'd0, pc_ff} << PcShift);
                           exp_in = exp_ff + 8'd1; pc_in = pc_ff + 16'd1;
                           st_in = ST_READ; word_in = '0; bsel_in = '0;
                        end
                     end else if (h0 == ChEot) begin
                        if (phase_ff == PH_DATA) begin
                           phase_in = PH_EOT2; st_in = ST_SEQ; seq_in = SqNak; step_in = '0;
                        end else if (phase_ff == PH_EOT2) begin
                           phase_in = PH_FINAL; st_in = ST_SEQ; seq_in = SqEot;
                           step_in = '0;
                        end
                     end
                  end else if (pos_cur < 11'(PosMax)) begin
                     pos_in = pos_cur + 11'd1;
                  end
               end
            end
         end
         ST_SEQ: begin
            if (!o_valid_in) begin
               o_valid_in = 1'b1; o_last_in = 1'b0; o_kind_in = KIND_BYTE; o_tx_in = '0;
               o_addr_in = '0; o_data_in = '0; o_rend_in = '0;
               step_in = step_ff + 2'd1;
               case (seq_ff)
                  SqStart: begin
                     if (step_ff == 2'd0) o_tx_in = ChAck;
                     else if (step_ff == 2'd1) o_tx_in = ChC;
                     else begin
                        o_kind_in = KIND_ERASE; o_addr_in = base_ff;
                        o_rend_in = base_ff + size_ff - 32'd1; o_last_in = 1'b1;
                     end
                  end
                  SqFinal: begin
                     if (step_ff == 2'd0) begin
                        o_kind_in = KIND_WRITE; o_addr_in = base_ff + size_ff - 32'd4;
                        o_data_in = done_ff;
                     end else if (step_ff == 2'd1) o_tx_in = ChAck;
                     else begin
                        o_kind_in = KIND_RESET; o_last_in = 1'b1;
                     end
                  end
                  SqNak: begin
                     o_tx_in = ChNak; o_last_in = 1'b1;
                  end
                  default: begin
                     if (step_ff == 2'd0) o_tx_in = ChAck;
                     else begin
                        o_tx_in = ChC; o_last_in = 1'b1;
                     end
                  end
               endcase
               if (o_last_in) st_in = ST_IDLE;
            end
         end
         ST_READ: begin
            bsel_in = bsel_ff + 2'd1;
            st_in = ST_WORD;
         end
         ST_WORD: begin
            acc_in = {ram_rdata, acc_ff[31:8]};
            if (bsel_ff == 2'd0) st_in = ST_OUT;
            else bsel_in = bsel_ff + 2'd1;
         end
         ST_OUT: begin
            if (!o_valid_in) begin
               o_valid_in = 1'b1; o_kind_in = KIND_WRITE; o_tx_in = '0;
               o_rend_in = '0; o_last_in = 1'b0;
               if (step_ff == 2'd1) begin
                  o_kind_in = KIND_BYTE; o_tx_in = ChAck; o_addr_in = '0;
                  o_data_in = '0; o_last_in = 1'b1; st_in = ST_IDLE; step_in = '0;
               end else begin
                  o_addr_in = wbase_ff + {{(32-WW-2){1'b0}}, word_ff, 2'b00};
                  o_data_in = acc_ff;
                  if (word_ff == WW'(NW - 1)) step_in = 2'd1;
                  else begin
                     word_in = word_ff + 1'b1; st_in = ST_READ; bsel_in = '0;
                  end
               end
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= 32'd134479872; size_ff <= 32'd262144; done_ff <= '0; poly_ff <= 16'h1021;
         phase_ff <= PH_START; exp_ff <= 8'd1; pc_ff <= '0; pos_ff <= '0; crc_ff <= '0;
         for (int i = 0; i < 5; i++) hdr_ff[i] <= '0;
         st_ff <= ST_IDLE; step_ff <= '0; o_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_BASE: base_ff <= csr_wdata;
               CSR_SIZE: size_ff <= csr_wdata;
               CSR_DONE: done_ff <= csr_wdata;
               CSR_POLY: poly_ff <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (accept && !req.op) begin
            hdr_ff[0] <= h0; hdr_ff[1] <= h1; hdr_ff[2] <= h2;
            hdr_ff[3] <= h3; hdr_ff[4] <= h4;
         end
         phase_ff <= phase_in; exp_ff <= exp_in; pc_ff <= pc_in; pos_ff <= pos_in;
         crc_ff <= crc_in; st_ff <= st_in; step_ff <= step_in; o_valid_ff <= o_valid_in;
      end
      seq_ff <= seq_in; word_ff <= word_in; bsel_ff <= bsel_in; acc_ff <= acc_in;
      wbase_ff <= wbase_in; o_last_ff <= o_last_in; o_kind_ff <= o_kind_in;
      o_tx_ff <= o_tx_in; o_addr_ff <= o_addr_in; o_data_ff <= o_data_in;
      o_rend_ff <= o_rend_in;
   end

   assign rsp.valid = o_valid_ff;
   assign rsp.kind = o_kind_ff;
   assign rsp.tx_byte = o_tx_ff;
   assign rsp.address = o_addr_ff;
   assign rsp.data_word = o_data_ff;
   assign rsp.region_end = o_rend_ff;
   assign rsp.last = o_last_ff;

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff != ST_IDLE) |-> !req.ready) else $error("item taken while busy");
   a_ram_quiet: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_READ || st_ff == ST_WORD) |-> !ram_we) else $error("ram write in drain");
   a_reset_last: assert property (@(posedge clock) disable iff (reset)
      (o_valid_ff && o_kind_ff == KIND_RESET) |-> o_last_ff) else $error("reset not last");
`endif
endmodule

// ===== tb/ymodem_receiver_with_crc16_tb.sv =====
// testbench: ymodem receiver with crc-16, driven by frames and poll ticks, checked by a predictor
module ymodem_receiver_with_crc16_tb;
   import ymr_pkg::*;

   typedef struct packed {
      logic       op;
      logic [7:0] rx_byte;
      logic       frame_end;
   } rx_item_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  tx_byte;
      logic [31:0] address;
      logic [31:0] data_word;
      logic [31:0] region_end;
      logic        last;
   } flash_op_type;

   typedef struct packed {
      rx_item_type  stim;
      logic         typed;
      flash_op_type want;
   } dir_row_type;

   localparam int PB = 128;
   localparam int FRAME_LEN = PB + 5;
   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   ymr_req_if req ();
   ymr_rsp_if rsp ();

   ymodem_receiver_with_crc16 i_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [31:0] cfg_base, cfg_size, cfg_done;
   logic [15:0] cfg_poly;
   phase_type   ph;
   logic [7:0]  exp_blk;
   logic [15:0] pkt_cnt;
   int unsigned pos;
   logic [15:0] crc_acc;
   logic [7:0]  hdr [5];
   logic [7:0]  payload [PB];

   flash_op_type expected_ops[$];
   rx_item_type  send_q[$];
   int errors = 0;
   int idle_cycles = 0;
   bit no_gaps = 1'b0;
   int hold_off = 0;

   task automatic report(input string what, input flash_op_type got, input flash_op_type w);
      errors++;
      $display("error %s: got k%0d tx%h a%h d%h e%h l%0d want k%0d tx%h a%h d%h e%h l%0d",
               what, got.kind, got.tx_byte, got.address, got.data_word, got.region_end,
               got.last, w.kind, w.tx_byte, w.address, w.data_word, w.region_end, w.last);
   endtask

   function automatic logic [15:0] crc_update(input logic [15:0] c0, input logic [7:0] b);
      logic [15:0] c;
      c = c0 ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) c = c[15] ? ({c[14:0], 1'b0} ^ cfg_poly) : {c[14:0], 1'b0};
      return c;
   endfunction

   function automatic flash_op_type mk(input kind_type k, input logic [7:0] tx,
                                       input logic [31:0] a, input logic [31:0] d,
                                       input logic [31:0] e);
      flash_op_type r;
      r.kind = k; r.tx_byte = tx; r.address = a; r.data_word = d; r.region_end = e;
      r.last = 1'b0;
      return r;
   endfunction

   task automatic close_frame(input int unsigned len, inout flash_op_type q[$]);
      logic [31:0] wbase;
      logic        cpl;
      cpl = hdr[2] == ~hdr[1];
      if (hdr[0] == ChSoh) begin
         if (len != FRAME_LEN || {hdr[3], hdr[4]} != crc_acc || !cpl) return;
         if (ph == PH_START && hdr[1] == 8'd0) begin
            ph = PH_DATA; exp_blk = 8'd1; pkt_cnt = '0;
            q.push_back(mk(KIND_BYTE, ChAck, 0, 0, 0));
            q.push_back(mk(KIND_BYTE, ChC, 0, 0, 0));
            q.push_back(mk(KIND_ERASE, 0, cfg_base, 0, cfg_base + cfg_size - 32'd1));
         end else if (ph == PH_FINAL && hdr[1] == 8'd0) begin
            ph = PH_START;
            q.push_back(mk(KIND_WRITE, 0, cfg_base + cfg_size - 32'd4, cfg_done, 0));
            q.push_back(mk(KIND_BYTE, ChAck, 0, 0, 0));
            q.push_back(mk(KIND_RESET, 0, 0, 0, 0));
         end else if (ph == PH_DATA && hdr[1] == exp_blk) begin
            wbase = cfg_base + 32'(pkt_cnt) * PB;
            for (int i = 0; i < PB / 4; i++)
               q.push_back(mk(KIND_WRITE, 0, wbase + 32'(4 * i),
                  {payload[4*i+3], payload[4*i+2], payload[4*i+1], payload[4*i]}, 0));
            exp_blk++; pkt_cnt++;
            q.push_back(mk(KIND_BYTE, ChAck, 0, 0, 0));
         end
      end else if (hdr[0] == ChEot) begin
         if (ph == PH_DATA) begin
            ph = PH_EOT2; q.push_back(mk(KIND_BYTE, ChNak, 0, 0, 0));
         end else if (ph == PH_EOT2) begin
            ph = PH_FINAL;
            q.push_back(mk(KIND_BYTE, ChAck, 0, 0, 0));
            q.push_back(mk(KIND_BYTE, ChC, 0, 0, 0));
         end
      end
   endtask

   task automatic predict(input rx_item_type it, output flash_op_type q[$]);
      q = {};
      if (it.op) begin
         if (ph == PH_START) q.push_back(mk(KIND_BYTE, ChC, 0, 0, 0));
      end else begin
         if (pos < 3) hdr[pos] = it.rx_byte;
         else if (pos < 3 + PB) begin
            payload[pos - 3] = it.rx_byte; crc_acc = crc_update(crc_acc, it.rx_byte);
         end else if (pos == 3 + PB) hdr[3] = it.rx_byte;
         else if (pos == 4 + PB) hdr[4] = it.rx_byte;
         if (it.frame_end) begin
            close_frame(pos + 1, q);
            pos = 0; crc_acc = '0;
         end else if (pos < PosMax) pos++;
      end
      if (q.size() > 0) q[q.size() - 1].last = 1'b1;
   endtask

   function automatic rx_item_type fb(input logic [7:0] b, input logic fe);
      rx_item_type r;
      r.op = 1'b0; r.rx_byte = b; r.frame_end = fe;
      return r;
   endfunction

   function automatic rx_item_type tick();
      rx_item_type r;
      r.op = 1'b1; r.rx_byte = 8'($urandom); r.frame_end = 1'($urandom);
      return r;
   endfunction

   // frame with correct crc under the configured polynomial, optionally corrupted
   task automatic queue_frame(input logic [7:0] blk, input int corrupt, input int lenadj,
                              input bit zero_pay);
      logic [7:0] p [PB];
      logic [15:0] c;
      int n;
      c = '0;
      for (int i = 0; i < PB; i++) begin
         p[i] = zero_pay ? 8'h00 : 8'($urandom);
         c = crc_update(c, p[i]);
      end
      if (corrupt == 1) c ^= 16'h0001;
      n = FRAME_LEN + lenadj;
      for (int i = 0; i < n; i++) begin
         logic [7:0] b;
         if (i == 0) b = ChSoh;
         else if (i == 1) b = blk;
         else if (i == 2) b = (corrupt == 2) ? blk : ~blk;
         else if (i < 3 + PB) b = p[i - 3];
         else if (i == 3 + PB) b = c[15:8];
         else if (i == 4 + PB) b = c[7:0];
         else b = 8'($urandom);
         send_q.push_back(fb(b, i == n - 1));
         if ($urandom_range(0, 40) == 0) send_q.push_back(tick());
      end
   endtask

   task automatic queue_eot(input int len);
      for (int i = 0; i < len; i++)
         send_q.push_back(fb(i == 0 ? ChEot : 8'($urandom), i == len - 1));
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [31:0] v);
      @(posedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_BASE: cfg_base = v;
         CSR_SIZE: cfg_size = v;
         CSR_DONE: cfg_done = v;
         default:  cfg_poly = v[15:0];
      endcase
   endtask

   task automatic drain();
      while (expected_ops.size() > 0 || send_q.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   // sender
   int gap = 0;
   always @(posedge clock) begin
      flash_op_type q[$];
      if (reset) begin
         req.valid <= 1'b0;
      end else begin
         if (req.valid && req.ready) begin
            predict({req.op, req.rx_byte, req.frame_end}, q);
            foreach (q[i]) expected_ops.push_back(q[i]);
            void'(send_q.pop_front());
         end
         if (gap > 0) gap--;
         else if (!no_gaps && $urandom_range(0, 15) == 0) gap = $urandom_range(1, 11);
         // an offered item stays until it is taken
         if (send_q.size() > 0 && (gap == 0 || (req.valid && !req.ready))) begin
            req.valid <= 1'b1;
            req.op <= send_q[0].op; req.rx_byte <= send_q[0].rx_byte;
            req.frame_end <= send_q[0].frame_end;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // receiver
   int stall = 0;
   always @(posedge clock) begin
      flash_op_type got;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            got = mk(kind_type'(rsp.kind), rsp.tx_byte, rsp.address, rsp.data_word,
                     rsp.region_end);
            got.last = rsp.last;
            if (expected_ops.size() == 0) report("unexpected", got, got);
            else if (got !== expected_ops[0]) report("mismatch", got, expected_ops.pop_front());
            else void'(expected_ops.pop_front());
         end
         if (hold_off > 0) begin
            hold_off--; rsp.ready <= 1'b0;
         end else if (stall > 0) begin
            stall--; rsp.ready <= 1'b0;
         end else if (!no_gaps && $urandom_range(0, 15) == 0) begin
            stall = $urandom_range(1, 11) - 1; rsp.ready <= 1'b0;
         end else rsp.ready <= 1'b1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || csr_we) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // directed rows: reset poll, poll with other bits set, eot out of phase, one-byte junk frame
   dir_row_type dir_rows [4] = '{
      '{'{1'b1, 8'h00, 1'b0}, 1'b1, '{KIND_BYTE, ChC, 32'h0, 32'h0, 32'h0, 1'b1}},
      '{'{1'b1, 8'hFF, 1'b1}, 1'b1, '{KIND_BYTE, ChC, 32'h0, 32'h0, 32'h0, 1'b1}},
      '{'{1'b0, ChEot, 1'b1}, 1'b0, '0},
      '{'{1'b0, 8'hFF, 1'b1}, 1'b0, '0}
   };

   initial begin
      cfg_base = 32'd134479872; cfg_size = 32'd262144; cfg_done = '0; cfg_poly = 16'h1021;
      ph = PH_START; exp_blk = 8'd1; pkt_cnt = '0; pos = 0; crc_acc = '0;
      foreach (hdr[i]) hdr[i] = '0;
      foreach (payload[i]) payload[i] = '0;
      req.valid = 1'b0; req.op = 1'b0; req.rx_byte = '0; req.frame_end = 1'b0;
      rsp.ready = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         int n0;
         while (expected_ops.size() > 0) @(posedge clock);
         n0 = expected_ops.size();
         send_q.push_back(dir_rows[i].stim);
         while (send_q.size() > 0) @(posedge clock);
         if (dir_rows[i].typed && (expected_ops.size() != n0 + 1
             || expected_ops[expected_ops.size() - 1] !== dir_rows[i].want))
            report("table", dir_rows[i].want, dir_rows[i].want);
      end
      drain();

      // extremes: base near the top, zero size, all-ones done and polynomial, zero payload
      csr_write(CSR_BASE, 32'hFFFF_FFF0); csr_write(CSR_SIZE, 32'h0);
      csr_write(CSR_DONE, 32'hFFFF_FFFF); csr_write(CSR_POLY, 32'h0000_FFFF);
      send_q.push_back(tick());
      queue_frame(8'd0, 0, 0, 1'b1);
      drain();

      // random data frame with the receiver held off, then a short tail
      csr_write(CSR_BASE, $urandom); csr_write(CSR_POLY, $urandom_range(0, 65535));
      hold_off = 400;
      queue_frame(8'd1, 0, 0, 1'b0);
      queue_frame(8'd2, 0, 6 - FRAME_LEN, 1'b0);
      queue_eot(1);
      send_q.push_back(tick());
      queue_eot(2);
      send_q.push_back(tick());
      repeat (3) send_q.push_back(fb(8'($urandom), 1'($urandom)));
      send_q.push_back(fb(8'h00, 1'b1));
      while (send_q.size() > 20) @(posedge clock);
      no_gaps = 1'b1;
      drain();

      if (errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

// ===== ymodem_receiver_with_crc16.f =====
sv/ymr_pkg.sv
sv/ymr_if.sv
sv/ymr_ram.sv
sv/ymodem_receiver_with_crc16.sv
tb/ymodem_receiver_with_crc16_tb.sv
